// ===== rtl/core/ufcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Union-find cycle detector package
// Shared widths, datapath operation codes and the controller/datapath
// interface structures.
// ----------------------------------------------------------------------------
package ufcd_pkg;

  localparam int VERT_W       = 10;
  localparam int SIZE_W       = 11;
  localparam int NUM_VERTICES = 1 << VERT_W;

  typedef logic [VERT_W-1:0] vert_t;
  typedef logic [SIZE_W-1:0] size_t;

  // Action field codes.
  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_LOAD   = 4'd1;
  localparam op_t OP_START  = 4'd2;
  localparam op_t OP_FIND   = 4'd3;
  localparam op_t OP_COMP   = 4'd4;
  localparam op_t OP_SIZE_A = 4'd5;
  localparam op_t OP_SIZE_B = 4'd6;
  localparam op_t OP_MERGE  = 4'd7;
  localparam op_t OP_EMIT   = 4'd8;
  localparam op_t OP_SWEEP  = 4'd9;

  typedef struct packed {
    op_t  op;
    logic phase_b;  // walk belongs to the second endpoint
  } cmd_t;

  typedef struct packed {
    logic is_clear;    // held item is a clear action
    logic is_error;    // held item has an endpoint out of range
    logic root_hit;    // link just read points at the node itself
    logic at_root;     // compression walker has reached the root
    logic sweep_last;  // clearing sweep is at its final entry
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

// ===== rtl/core/ufcd_datapath.sv =====
// ----------------------------------------------------------------------------
// Union-find datapath
// Parent and size memories, the walk pointer, root and size registers,
// the sticky cycle flag, the vertex count register and the output register.
// ----------------------------------------------------------------------------
module ufcd_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ufcd_pkg::cmd_t        cmd,
  output ufcd_pkg::status_t     status,
  input  logic                  cfg_write,
  input  ufcd_pkg::size_t       cfg_data,
  input  logic                  action,
  input  ufcd_pkg::vert_t       first_vertex,
  input  ufcd_pkg::vert_t       second_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  closes_cycle,
  output logic                  cycle_seen,
  output logic                  vertex_error,
  output ufcd_pkg::size_t       merged_size
);

  import ufcd_pkg::*;

  // Memories.
  vert_t parent_mem [NUM_VERTICES];
  size_t size_mem   [NUM_VERTICES];
  vert_t parent_q;
  size_t size_q;

  // Control registers.
  size_t vertex_count;
  logic  act_q;
  logic  err_q;
  logic  cycle_flag;
  vert_t sweep_cnt;

  // Payload registers.
  vert_t va, vb, cur, root_a, root_b;
  size_t size_a;
  logic  res_closes;
  size_t res_size;

  // Memory port controls.
  vert_t parent_raddr, parent_waddr, parent_wdata;
  logic  parent_we;
  vert_t size_raddr, size_waddr;
  size_t size_wdata;
  logic  size_we;

  vert_t start_v, root_cur;
  logic  root_hit, at_root;
  logic  out_free;
  logic  a_smaller;
  size_t size_sum;

  assign start_v  = cmd.phase_b ? vb : va;
  assign root_cur = cmd.phase_b ? root_b : root_a;
  assign root_hit = (parent_q == cur);
  assign at_root  = (cur == root_cur);
  assign out_free = !out_valid || !out_stall;

  assign a_smaller = (size_a < size_q);
  assign size_sum  = size_a + size_q;

  assign status.is_clear   = act_q;
  assign status.is_error   = err_q;
  assign status.root_hit   = root_hit;
  assign status.at_root    = at_root;
  assign status.sweep_last = (sweep_cnt == vert_t'(NUM_VERTICES - 1));
  assign status.out_free   = out_free;

  always_comb begin
    parent_raddr = cur;
    parent_waddr = cur;
    parent_wdata = root_cur;
    parent_we    = 1'b0;
    size_raddr   = root_b;
    size_waddr   = root_a;
    size_wdata   = size_sum;
    size_we      = 1'b0;
    case (cmd.op)
      OP_START: begin
        parent_raddr = start_v;
      end
      OP_FIND: begin
        parent_raddr = root_hit ? start_v : parent_q;
      end
      OP_COMP: begin
        parent_raddr = parent_q;
        parent_we    = !at_root;
      end
      OP_SIZE_A: begin
        size_raddr = root_a;
      end
      OP_MERGE: begin
        if (root_a != root_b) begin
          parent_we = 1'b1;
          size_we   = 1'b1;
          if (a_smaller) begin
            parent_waddr = root_a;
            parent_wdata = root_b;
            size_waddr   = root_b;
          end else begin
            parent_waddr = root_b;
            parent_wdata = root_a;
            size_waddr   = root_a;
          end
        end
      end
      OP_SWEEP: begin
        parent_we    = 1'b1;
        parent_waddr = sweep_cnt;
        parent_wdata = sweep_cnt;
        size_we      = 1'b1;
        size_waddr   = sweep_cnt;
        size_wdata   = size_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (parent_we) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_q <= parent_mem[parent_raddr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_q <= size_mem[size_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= size_t'(NUM_VERTICES);
      act_q        <= 1'b0;
      err_q        <= 1'b0;
      cycle_flag   <= 1'b0;
      sweep_cnt    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (cmd.op == OP_LOAD) begin
        act_q <= (action == ACT_CLEAR);
        err_q <= ({1'b0, first_vertex} >= vertex_count) ||
                 ({1'b0, second_vertex} >= vertex_count);
      end
      if (cmd.op == OP_SWEEP) begin
        sweep_cnt  <= sweep_cnt + vert_t'(1);
        cycle_flag <= 1'b0;
      end
      if (cmd.op == OP_MERGE && root_a == root_b) begin
        cycle_flag <= 1'b1;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        va <= first_vertex;
        vb <= second_vertex;
      end
      OP_START: begin
        cur <= start_v;
      end
      OP_FIND: begin
        if (root_hit) begin
          if (cmd.phase_b) begin
            root_b <= cur;
          end else begin
            root_a <= cur;
          end
          cur <= start_v;
        end else begin
          cur <= parent_q;
        end
      end
      OP_COMP: begin
        cur <= parent_q;
      end
      OP_SIZE_B: begin
        size_a <= size_q;
      end
      OP_MERGE: begin
        res_closes <= (root_a == root_b);
        if (root_a == root_b) begin
          res_size <= size_a;
        end else begin
          res_size <= size_sum;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      if (act_q) begin
        closes_cycle <= 1'b0;
        cycle_seen   <= 1'b0;
        vertex_error <= 1'b0;
        merged_size  <= size_t'(1);
      end else if (err_q) begin
        closes_cycle <= 1'b0;
        cycle_seen   <= cycle_flag;
        vertex_error <= 1'b1;
        merged_size  <= '0;
      end else begin
        closes_cycle <= res_closes;
        cycle_seen   <= cycle_flag;
        vertex_error <= 1'b0;
        merged_size  <= res_size;
      end
    end
  end

endmodule

// ===== rtl/core/ufcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Union-find controller
// Sequences the clearing sweep, the two root walks with path compression,
// the merge and the result handoff.
// ----------------------------------------------------------------------------
module ufcd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ufcd_pkg::status_t     status,
  output ufcd_pkg::cmd_t        cmd
);

  import ufcd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_COMP  = 4'd4;
  localparam logic [3:0] S_SZA   = 4'd5;
  localparam logic [3:0] S_SZB   = 4'd6;
  localparam logic [3:0] S_MERGE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;

  logic [3:0] state, state_next;
  logic       phase, phase_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    cmd.op      = OP_NONE;
    cmd.phase_b = phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        phase_next = 1'b0;
        if (status.is_clear) begin
          state_next = S_CLR;
        end else if (status.is_error) begin
          state_next = S_OUT;
        end else begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.op     = OP_START;
        state_next = S_FIND;
      end
      S_FIND: begin
        cmd.op = OP_FIND;
        if (status.root_hit) begin
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        cmd.op = OP_COMP;
        if (status.at_root) begin
          if (phase) begin
            state_next = S_SZA;
          end else begin
            phase_next = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_SZA: begin
        cmd.op     = OP_SIZE_A;
        state_next = S_SZB;
      end
      S_SZB: begin
        cmd.op     = OP_SIZE_B;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.op     = OP_MERGE;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.op = OP_SWEEP;
        if (status.sweep_last) begin
          state_next = status.is_clear ? S_OUT : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== rtl/core/union_find_cycle_detector.sv =====
// ----------------------------------------------------------------------------
// Union-find cycle detector
// Disjoint-set engine with path compression and union by size that flags
// edges closing a cycle in an undirected graph.
// ----------------------------------------------------------------------------
// Usage:
// Edges arrive on the input channel (in_valid / in_stall) as an action bit
// and two vertex indices. Every input transfer produces exactly one result
// transfer on the output channel (out_valid / out_stall). The vertex_count
// register is written through cfg_write / cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// With both endpoints at their roots, an input transfer runs through a
// dispatch step, a start, a find and a compression step per endpoint, two
// size reads, the merge and the handoff, which waits for a free output
// register. Each level of the parent chain between an endpoint and its root
// adds a find step and a compression step, since the single read port of
// the parent memory is visited once per level. in_stall drops in the same
// cycle that out_valid rises. An endpoint out of range goes from the
// dispatch step straight to the handoff. A clear action sweeps the whole
// parent and size memories, one entry per cycle, and then hands off its
// result. After reset the same sweep over all 1024 entries runs and
// in_stall stays high until it ends; configuration writes are taken during
// the sweep. A finished result sits in the output register until the
// receiver drops out_stall; meanwhile the next edge is taken and worked on,
// and it waits only for its own result handoff.
// ----------------------------------------------------------------------------
module union_find_cycle_detector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  ufcd_pkg::size_t       cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  ufcd_pkg::vert_t       first_vertex,
  input  ufcd_pkg::vert_t       second_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  closes_cycle,
  output logic                  cycle_seen,
  output logic                  vertex_error,
  output ufcd_pkg::size_t       merged_size
);

  import ufcd_pkg::*;

  // The controller issues at most one datapath operation per cycle and steers on
  // the status flags that come back.
  cmd_t    cmd;
  status_t status;

  ufcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the memories, the walk registers and the output
  // register that separates result handoff from the next edge's work.
  ufcd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .action        (action),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .closes_cycle  (closes_cycle),
    .cycle_seen    (cycle_seen),
    .vertex_error  (vertex_error),
    .merged_size   (merged_size)
  );

endmodule
